// ----- src/brg_pkg.sv -----
// package for the bounded random generator: constants, state codes, command and status types
`default_nettype none

package brg_pkg;

  // field and datapath widths
  localparam int unsigned SeedW  = 31;
  localparam int unsigned MultW  = 15;
  localparam int unsigned ProdW  = SeedW + MultW;
  localparam int unsigned DivCntW = $clog2(SeedW);

  // generator constants
  localparam logic [MultW-1:0]   LcgMult  = MultW'(16807);
  localparam logic [SeedW-1:0]   LcgMod   = {SeedW{1'b1}};
  localparam logic [SeedW-1:0]   SeedInit = SeedW'(1);
  localparam logic [DivCntW-1:0] DivLast  = DivCntW'(SeedW - 1);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_DIV,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the request bound
    logic mul;       // seed times multiplier
    logic fold;      // reduce modulo 2^31-1, update seed, start remainder
    logic div_step;  // one restoring remainder step
    logic out_load;  // move the result into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;  // current remainder step is the final one
  } sts_t;

endpackage

`default_nettype wire

// ----- src/brg_dp.sv -----
// datapath: seed register, multiplier, mersenne fold, radix-2 remainder unit, result register
`default_nettype none

module brg_dp import brg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  input  wire logic [SeedW-1:0] bound_i,
  output logic      [SeedW-1:0] value_o,
  output logic                  bound_zero_o
);

  logic [SeedW-1:0]   seed_q, seed_d;
  logic [SeedW-1:0]   bound_q;
  logic [ProdW-1:0]   prod_q;
  logic [SeedW-1:0]   quo_q, quo_d;
  logic [SeedW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SeedW-1:0]   value_q;
  logic               zero_q;

  logic [SeedW-1:0]   seed_src;
  logic [SeedW:0]     fold_sum;
  logic [SeedW:0]     fold_res;
  logic [SeedW:0]     rem_shift;
  logic [SeedW:0]     rem_sub;
  logic               bound_is_zero;

  // zero seed is forced back to one before the step
  assign seed_src = (seed_q == '0) ? SeedInit : seed_q;

  // fold of the 46-bit product: low 31 bits plus high bits, one conditional subtract
  assign fold_sum = {1'b0, prod_q[SeedW-1:0]} + (SeedW+1)'(prod_q[ProdW-1:SeedW]);
  assign fold_res = (fold_sum >= {1'b0, LcgMod}) ? (fold_sum - {1'b0, LcgMod}) : fold_sum;

  // one restoring step: shift in next dividend bit, subtract bound if it fits
  assign rem_shift = {rem_q, quo_q[SeedW-1]};
  assign rem_sub   = rem_shift - {1'b0, bound_q};

  assign bound_is_zero = (bound_q == '0);

  // next values of seed, dividend, remainder and step counter
  always_comb begin
    seed_d = seed_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (cmd_i.fold) begin
      seed_d = fold_res[SeedW-1:0];
      quo_d  = fold_res[SeedW-1:0];
      rem_d  = '0;
      cnt_d  = '0;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[SeedW-2:0], 1'b0};
      rem_d = (rem_shift >= {1'b0, bound_q}) ? rem_sub[SeedW-1:0] : rem_shift[SeedW-1:0];
      cnt_d = cnt_q + DivCntW'(1);
    end
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedInit;
      cnt_q  <= '0;
    end else begin
      seed_q <= seed_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bound_q <= bound_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(seed_src) * ProdW'(LcgMult);
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.out_load) begin
      value_q <= bound_is_zero ? '0 : rem_q;
      zero_q  <= bound_is_zero;
    end
  end

  assign sts_o.div_last = (cnt_q == DivLast);
  assign value_o        = value_q;
  assign bound_zero_o   = zero_q;

endmodule

`default_nettype wire

// ----- src/brg_ctrl.sv -----
// controller: request sequencing and output handshake
`default_nettype none

module brg_ctrl import brg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_FOLD;
      ST_FOLD: state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_last) begin
        state_d = ST_DONE;
      end
      ST_DONE: if (out_free) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load     = accept;
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_FOLD: cmd_o.fold     = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // an accepted request goes straight to the multiply
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_MUL)
    else $error("accepted request did not start the multiply");

  // the final remainder step hands over to the result stage
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && sts_i.div_last |=> state_q == ST_DONE)
    else $error("remainder unit overran its step count");

  // a finished result is never dropped while the output is full and stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || !out_stall_i)
    else $error("result loaded over a stalled output");

  // leaving the result stage always leaves a valid output behind
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("result stage left without presenting a result");

endmodule

`default_nettype wire

// ----- src/bounded_random_generator.sv -----
// top level of the bounded random generator: controller and datapath
//
// channel  direction  handshake                  payload
// in       request    in_valid_i / in_stall_o    bound_i[30:0]
// out      result     out_valid_o / out_stall_i  value_o[30:0], bound_zero_o
//
// a request passes from acceptance to its result through the 31x15 multiply, the
// modulo 2^31-1 fold, the radix-2 remainder by the bound and the load of the output
// register; the bound is captured at acceptance.
// the remainder unit handles one request at a time; a new request can be taken as soon
// as the result is in the output register, even while that result is stalled.
// a stalled result holds the next one in the result stage, and the input stalls.
// reset sets the seed to one and empties the output register.
`default_nettype none

module bounded_random_generator import brg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [SeedW-1:0] bound_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [SeedW-1:0] value_o,
  output logic                  bound_zero_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing and handshakes
  brg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // arithmetic and result storage
  brg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .bound_i      (bound_i),
    .value_o      (value_o),
    .bound_zero_o (bound_zero_o)
  );

endmodule

`default_nettype wire
